// File: src/qrs_pkg.sv
package qrs_pkg;

    // Fixed widths of the data path.
    localparam int COEF_W = 32;
    localparam int EPS_W  = 16;
    localparam int DIFF_W = 33;
    localparam int PROD_W = 66;
    localparam int DISC_W = 68;
    localparam int ROOT_W = 34;
    localparam int REM_W  = 37;
    localparam int NUM_W  = 36;
    localparam int NMAG_W = 35;
    localparam int DEN_W  = 35;
    localparam int DMAG_W = 34;

    // Solution kinds.
    localparam logic [2:0] KIND_ALL     = 3'd0;
    localparam logic [2:0] KIND_NONE    = 3'd1;
    localparam logic [2:0] KIND_LINEAR  = 3'd2;
    localparam logic [2:0] KIND_DOUBLE  = 3'd3;
    localparam logic [2:0] KIND_TWO     = 3'd4;
    localparam logic [2:0] KIND_COMPLEX = 3'd5;

    // Saturation bounds of a root.
    localparam logic [COEF_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [COEF_W-1:0] SAT_MIN = 32'h8000_0000;

    // One classified equation as it waits between the front and the back.
    typedef struct packed {
        logic [2:0]               kind;
        logic signed [DIFF_W-1:0] a;
        logic signed [DIFF_W-1:0] b;
        logic signed [DIFF_W-1:0] c;
        logic [DISC_W-1:0]        disc;
    } t_job;

    // State of one square-root stage.
    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [DISC_W-1:0] rad;
    } t_sq;

    // One restoring square-root step: two radicand bits in, one root bit out.
    function automatic t_sq sq_step(input t_sq s);
        t_sq r;
        logic [REM_W-1:0] t;
        logic [REM_W-1:0] trial;
        t     = {s.rem[REM_W-3:0], s.rad[DISC_W-1 -: 2]};
        trial = {{(REM_W-ROOT_W-2){1'b0}}, s.root, 2'b01};
        r.rad = {s.rad[DISC_W-3:0], 2'b00};
        if (t >= trial) begin
            r.rem  = t - trial;
            r.root = {s.root[ROOT_W-2:0], 1'b1};
        end else begin
            r.rem  = t;
            r.root = {s.root[ROOT_W-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

// File: src/qrs_if.sv
// Input channel: one word carries the six coefficients.
interface qrs_in_if;
    logic valid;
    logic ready;
    logic signed [qrs_pkg::COEF_W-1:0] coef_left_square;
    logic signed [qrs_pkg::COEF_W-1:0] coef_left_linear;
    logic signed [qrs_pkg::COEF_W-1:0] coef_left_const;
    logic signed [qrs_pkg::COEF_W-1:0] coef_right_square;
    logic signed [qrs_pkg::COEF_W-1:0] coef_right_linear;
    logic signed [qrs_pkg::COEF_W-1:0] coef_right_const;

    modport source (
        output valid, coef_left_square, coef_left_linear, coef_left_const,
        output coef_right_square, coef_right_linear, coef_right_const,
        input  ready
    );
    modport sink (
        input  valid, coef_left_square, coef_left_linear, coef_left_const,
        input  coef_right_square, coef_right_linear, coef_right_const,
        output ready
    );
endinterface

// Output channel: one word carries the solution.
interface qrs_out_if;
    logic valid;
    logic ready;
    logic [2:0] solution_kind;
    logic signed [qrs_pkg::COEF_W-1:0] root_low;
    logic signed [qrs_pkg::COEF_W-1:0] root_high;
    logic overflow;

    modport source (
        output valid, solution_kind, root_low, root_high, overflow,
        input  ready
    );
    modport sink (
        input  valid, solution_kind, root_low, root_high, overflow,
        output ready
    );
endinterface

// File: src/qrs_front.sv
module qrs_front #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [qrs_pkg::EPS_W-1:0]  i_eps,
    qrs_in_if.sink                     i_in,
    output qrs_pkg::t_job              o_job,
    output logic                       o_job_valid,
    input  logic                       i_job_ready
);

    logic                              w_en;
    logic [qrs_pkg::EPS_W-1:0]         w_thr;
    logic [4:0]                        r_vld;

    logic signed [qrs_pkg::DIFF_W-1:0] r1_a, r1_b, r1_c;
    logic signed [qrs_pkg::DIFF_W-1:0] r2_a, r2_b, r2_c;
    logic [qrs_pkg::DIFF_W-1:0]        r2_ma, r2_mb, r2_mc;
    logic                              r2_za, r2_zb, r2_zc;
    logic [qrs_pkg::DIFF_W-1:0]        w_ma, w_mb, w_mc;

    logic signed [qrs_pkg::DIFF_W-1:0] r3_a, r3_b, r3_c;
    logic [qrs_pkg::PROD_W-1:0]        r3_b2, r3_p;
    logic                              r3_za, r3_zb, r3_zc, r3_opp;

    logic signed [qrs_pkg::DIFF_W-1:0] r4_a, r4_b, r4_c;
    logic                              r4_za, r4_zb, r4_zc;
    logic [qrs_pkg::DISC_W-1:0]        r4_d;
    logic                              r4_neg;
    logic [qrs_pkg::DISC_W-1:0]        w_q, w_b2, w_sum, w_rsub;
    logic [qrs_pkg::DISC_W:0]          w_sub;
    logic [qrs_pkg::DISC_W-1:0]        w_d;
    logic                              w_neg;

    qrs_pkg::t_job                     r5_job;
    logic [2:0]                        w_kind;
    logic [qrs_pkg::DISC_W-1:0]        w_dthr;

    // A zero threshold behaves as one least significant bit.
    assign w_thr = (i_eps == '0) ? qrs_pkg::EPS_W'(1) : i_eps;

    // The whole front advances unless its last word cannot enter the queue.
    assign w_en       = !r_vld[4] || i_job_ready;
    assign i_in.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[3:0], i_in.valid};
        end
    end

    // Stage 1: subtract the two sides exactly.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_a <= {i_in.coef_left_square[31], i_in.coef_left_square}
                  - {i_in.coef_right_square[31], i_in.coef_right_square};
            r1_b <= {i_in.coef_left_linear[31], i_in.coef_left_linear}
                  - {i_in.coef_right_linear[31], i_in.coef_right_linear};
            r1_c <= {i_in.coef_left_const[31], i_in.coef_left_const}
                  - {i_in.coef_right_const[31], i_in.coef_right_const};
        end
    end

    // Stage 2: magnitudes and zero tests.
    assign w_ma = r1_a[qrs_pkg::DIFF_W-1] ? qrs_pkg::DIFF_W'(-r1_a) : qrs_pkg::DIFF_W'(r1_a);
    assign w_mb = r1_b[qrs_pkg::DIFF_W-1] ? qrs_pkg::DIFF_W'(-r1_b) : qrs_pkg::DIFF_W'(r1_b);
    assign w_mc = r1_c[qrs_pkg::DIFF_W-1] ? qrs_pkg::DIFF_W'(-r1_c) : qrs_pkg::DIFF_W'(r1_c);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_a  <= r1_a;
            r2_b  <= r1_b;
            r2_c  <= r1_c;
            r2_ma <= w_ma;
            r2_mb <= w_mb;
            r2_mc <= w_mc;
            r2_za <= w_ma < qrs_pkg::DIFF_W'(w_thr);
            r2_zb <= w_mb < qrs_pkg::DIFF_W'(w_thr);
            r2_zc <= w_mc < qrs_pkg::DIFF_W'(w_thr);
        end
    end

    // Stage 3: the two products of the discriminant.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_a   <= r2_a;
            r3_b   <= r2_b;
            r3_c   <= r2_c;
            r3_za  <= r2_za;
            r3_zb  <= r2_zb;
            r3_zc  <= r2_zc;
            r3_b2  <= qrs_pkg::PROD_W'(r2_mb) * qrs_pkg::PROD_W'(r2_mb);
            r3_p   <= qrs_pkg::PROD_W'(r2_ma) * qrs_pkg::PROD_W'(r2_mc);
            r3_opp <= r2_a[qrs_pkg::DIFF_W-1] != r2_c[qrs_pkg::DIFF_W-1];
        end
    end

    // Stage 4: magnitude and sign of B*B - 4*A*C.
    assign w_q    = {r3_p, 2'b00};
    assign w_b2   = {2'b00, r3_b2};
    assign w_sum  = w_b2 + w_q;
    assign w_sub  = {1'b0, w_b2} - {1'b0, w_q};
    assign w_rsub = w_q - w_b2;

    always_comb begin
        if (r3_p == '0 || r3_opp) begin
            w_d   = w_sum;
            w_neg = 1'b0;
        end else if (!w_sub[qrs_pkg::DISC_W]) begin
            w_d   = w_sub[qrs_pkg::DISC_W-1:0];
            w_neg = 1'b0;
        end else begin
            w_d   = w_rsub;
            w_neg = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_a   <= r3_a;
            r4_b   <= r3_b;
            r4_c   <= r3_c;
            r4_za  <= r3_za;
            r4_zb  <= r3_zb;
            r4_zc  <= r3_zc;
            r4_d   <= w_d;
            r4_neg <= w_neg;
        end
    end

    // Stage 5: pick the kind of solution.
    assign w_dthr = qrs_pkg::DISC_W'(w_thr) << FRACTION_BITS;

    always_comb begin
        if (r4_za) begin
            if (r4_zb) begin
                w_kind = r4_zc ? qrs_pkg::KIND_ALL : qrs_pkg::KIND_NONE;
            end else begin
                w_kind = qrs_pkg::KIND_LINEAR;
            end
        end else if (r4_d < w_dthr) begin
            w_kind = qrs_pkg::KIND_DOUBLE;
        end else begin
            w_kind = r4_neg ? qrs_pkg::KIND_COMPLEX : qrs_pkg::KIND_TWO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_job.kind <= w_kind;
            r5_job.a    <= r4_a;
            r5_job.b    <= r4_b;
            r5_job.c    <= r4_c;
            r5_job.disc <= r4_d;
        end
    end

    assign o_job       = r5_job;
    assign o_job_valid = r_vld[4];

endmodule

// File: src/qrs_queue.sv
module qrs_queue #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  qrs_pkg::t_job i_data,
    output logic          o_full,
    input  logic          i_pop,
    output qrs_pkg::t_job o_data,
    output logic          o_empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    qrs_pkg::t_job r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;

    // Storage is written at the tail.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assign o_data  = r_mem[r_rd];
    assign o_full  = r_cnt == CW'(DEPTH);
    assign o_empty = r_cnt == '0;

endmodule

// File: src/qrs_back.sv
module qrs_back #(
    parameter int FRACTION_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  qrs_pkg::t_job i_job,
    input  logic          i_job_valid,
    output logic          o_job_pop,
    qrs_out_if.source     o_out
);

    localparam int SQ = qrs_pkg::ROOT_W;
    localparam int NW = qrs_pkg::NMAG_W + FRACTION_BITS;
    localparam int QW = NW + 1;

    typedef struct packed {
        logic [qrs_pkg::DMAG_W-1:0] rem;
        logic [NW-1:0]              nq;
        logic [qrs_pkg::DMAG_W-1:0] den;
        logic                       neg;
    } t_dv;

    // One restoring division step: one quotient bit.
    function automatic t_dv dv_step(input t_dv s);
        t_dv r;
        logic [qrs_pkg::DMAG_W:0] t;
        t = {s.rem, s.nq[NW-1]};
        r = s;
        if (t >= {1'b0, s.den}) begin
            r.rem = qrs_pkg::DMAG_W'(t - {1'b0, s.den});
            r.nq  = {s.nq[NW-2:0], 1'b1};
        end else begin
            r.rem = t[qrs_pkg::DMAG_W-1:0];
            r.nq  = {s.nq[NW-2:0], 1'b0};
        end
        return r;
    endfunction

    // Splits a signed quotient into magnitudes and the result sign.
    function automatic t_dv dv_load(input logic signed [qrs_pkg::NUM_W-1:0] n,
                                    input logic signed [qrs_pkg::DEN_W-1:0] d);
        t_dv r;
        logic [qrs_pkg::NUM_W-1:0] nm;
        logic [qrs_pkg::DEN_W-1:0] dm;
        nm    = n[qrs_pkg::NUM_W-1] ? qrs_pkg::NUM_W'(-n) : qrs_pkg::NUM_W'(n);
        dm    = d[qrs_pkg::DEN_W-1] ? qrs_pkg::DEN_W'(-d) : qrs_pkg::DEN_W'(d);
        r.rem = '0;
        r.nq  = {nm[qrs_pkg::NMAG_W-1:0], {FRACTION_BITS{1'b0}}};
        r.den = dm[qrs_pkg::DMAG_W-1:0];
        r.neg = n[qrs_pkg::NUM_W-1] ^ d[qrs_pkg::DEN_W-1];
        return r;
    endfunction

    // Clamps a quotient to 32 bits; the top bit flags saturation.
    function automatic logic [qrs_pkg::COEF_W:0] sat(input logic signed [QW-1:0] v);
        logic [qrs_pkg::COEF_W:0] r;
        if (v > $signed({{(QW-qrs_pkg::COEF_W){1'b0}}, qrs_pkg::SAT_MAX})) begin
            r = {1'b1, qrs_pkg::SAT_MAX};
        end else if (v < $signed({{(QW-qrs_pkg::COEF_W){1'b1}}, qrs_pkg::SAT_MIN})) begin
            r = {1'b1, qrs_pkg::SAT_MIN};
        end else begin
            r = {1'b0, v[qrs_pkg::COEF_W-1:0]};
        end
        return r;
    endfunction

    logic                              w_en;

    logic [SQ:0]                       r_sqv;
    qrs_pkg::t_sq                      r_sq  [SQ+1];
    qrs_pkg::t_job                     r_sqj [SQ+1];

    logic                              r_ppv;
    logic [2:0]                        r_pp_kind;
    logic signed [qrs_pkg::NUM_W-1:0]  r_pp_n1, r_pp_n2;
    logic signed [qrs_pkg::DEN_W-1:0]  r_pp_d1, r_pp_d2;
    logic signed [qrs_pkg::NUM_W-1:0]  w_s, w_b, w_c, w_n1, w_n2;
    logic signed [qrs_pkg::DEN_W-1:0]  w_a2, w_d1, w_d2;
    qrs_pkg::t_job                     w_pj;

    logic [NW:0]                       r_dvv;
    t_dv                               r_d1  [NW+1];
    t_dv                               r_d2  [NW+1];
    logic [2:0]                        r_dvk [NW+1];

    logic                              r_qv;
    logic [2:0]                        r_q_kind;
    logic signed [QW-1:0]              r_q1, r_q2;
    logic signed [QW-1:0]              w_u1, w_u2;

    logic                              r_sv;
    logic [2:0]                        r_s_kind;
    logic signed [QW-1:0]              r_s_lo, r_s_hi;

    logic                              r_out_valid;
    logic [2:0]                        r_out_kind;
    logic [qrs_pkg::COEF_W-1:0]        r_out_lo, r_out_hi;
    logic                              r_out_ovf;
    logic [qrs_pkg::COEF_W:0]          w_sat_lo, w_sat_hi;
    logic [qrs_pkg::COEF_W-1:0]        w_lo, w_hi;
    logic                              w_ovf;

    // The back advances as one pipeline whenever the output register is free.
    assign w_en      = !r_out_valid || o_out.ready;
    assign o_job_pop = w_en && i_job_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sqv       <= '0;
            r_ppv       <= 1'b0;
            r_dvv       <= '0;
            r_qv        <= 1'b0;
            r_sv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_sqv       <= {r_sqv[SQ-1:0], i_job_valid};
            r_ppv       <= r_sqv[SQ];
            r_dvv       <= {r_dvv[NW-1:0], r_ppv};
            r_qv        <= r_dvv[NW];
            r_sv        <= r_qv;
            r_out_valid <= r_sv;
        end
    end

    // Square root of the discriminant magnitude, one root bit per stage.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sq[0].rem  <= '0;
            r_sq[0].root <= '0;
            r_sq[0].rad  <= i_job.disc;
            r_sqj[0]     <= i_job;
            for (int k = 1; k <= SQ; k++) begin
                r_sq[k]  <= qrs_pkg::sq_step(r_sq[k-1]);
                r_sqj[k] <= r_sqj[k-1];
            end
        end
    end

    // Numerators and denominators of the two quotients for each kind.
    assign w_pj = r_sqj[SQ];
    assign w_s  = {2'b00, r_sq[SQ].root};
    assign w_b  = {{3{w_pj.b[qrs_pkg::DIFF_W-1]}}, w_pj.b};
    assign w_c  = {{3{w_pj.c[qrs_pkg::DIFF_W-1]}}, w_pj.c};
    assign w_a2 = {w_pj.a[qrs_pkg::DIFF_W-1], w_pj.a, 1'b0};

    always_comb begin
        w_n1 = '0;
        w_n2 = '0;
        w_d1 = qrs_pkg::DEN_W'(1);
        w_d2 = qrs_pkg::DEN_W'(1);
        case (w_pj.kind)
            qrs_pkg::KIND_LINEAR: begin
                w_n1 = -w_c;
                w_d1 = {{2{w_pj.b[qrs_pkg::DIFF_W-1]}}, w_pj.b};
            end
            qrs_pkg::KIND_DOUBLE: begin
                w_n1 = -w_b;
                w_d1 = w_a2;
            end
            qrs_pkg::KIND_TWO: begin
                w_n1 = w_s - w_b;
                w_n2 = -w_b - w_s;
                w_d1 = w_a2;
                w_d2 = w_a2;
            end
            qrs_pkg::KIND_COMPLEX: begin
                // The imaginary part divides by |2A|; flip the root instead.
                w_n1 = -w_b;
                w_n2 = w_pj.a[qrs_pkg::DIFF_W-1] ? -w_s : w_s;
                w_d1 = w_a2;
                w_d2 = w_a2;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pp_kind <= w_pj.kind;
            r_pp_n1   <= w_n1;
            r_pp_n2   <= w_n2;
            r_pp_d1   <= w_d1;
            r_pp_d2   <= w_d2;
        end
    end

    // Two division pipelines, one quotient bit per stage.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d1[0]  <= dv_load(r_pp_n1, r_pp_d1);
            r_d2[0]  <= dv_load(r_pp_n2, r_pp_d2);
            r_dvk[0] <= r_pp_kind;
            for (int k = 1; k <= NW; k++) begin
                r_d1[k]  <= dv_step(r_d1[k-1]);
                r_d2[k]  <= dv_step(r_d2[k-1]);
                r_dvk[k] <= r_dvk[k-1];
            end
        end
    end

    // Restore the quotient signs.
    assign w_u1 = $signed({1'b0, r_d1[NW].nq});
    assign w_u2 = $signed({1'b0, r_d2[NW].nq});

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_q_kind <= r_dvk[NW];
            r_q1     <= r_d1[NW].neg ? -w_u1 : w_u1;
            r_q2     <= r_d2[NW].neg ? -w_u2 : w_u2;
        end
    end

    // Two real roots leave in ascending order.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s_kind <= r_q_kind;
            if (r_q_kind == qrs_pkg::KIND_TWO && r_q2 < r_q1) begin
                r_s_lo <= r_q2;
                r_s_hi <= r_q1;
            end else begin
                r_s_lo <= r_q1;
                r_s_hi <= r_q2;
            end
        end
    end

    // Saturate and zero the unused fields.
    assign w_sat_lo = sat(r_s_lo);
    assign w_sat_hi = sat(r_s_hi);

    always_comb begin
        case (r_s_kind)
            qrs_pkg::KIND_ALL, qrs_pkg::KIND_NONE: begin
                w_lo  = '0;
                w_hi  = '0;
                w_ovf = 1'b0;
            end
            qrs_pkg::KIND_LINEAR, qrs_pkg::KIND_DOUBLE: begin
                w_lo  = w_sat_lo[qrs_pkg::COEF_W-1:0];
                w_hi  = '0;
                w_ovf = w_sat_lo[qrs_pkg::COEF_W];
            end
            default: begin
                w_lo  = w_sat_lo[qrs_pkg::COEF_W-1:0];
                w_hi  = w_sat_hi[qrs_pkg::COEF_W-1:0];
                w_ovf = w_sat_lo[qrs_pkg::COEF_W] | w_sat_hi[qrs_pkg::COEF_W];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_kind <= r_s_kind;
            r_out_lo   <= w_lo;
            r_out_hi   <= w_hi;
            r_out_ovf  <= w_ovf;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.solution_kind = r_out_kind;
    assign o_out.root_low      = $signed(r_out_lo);
    assign o_out.root_high     = $signed(r_out_hi);
    assign o_out.overflow      = r_out_ovf;

endmodule

// File: src/quadratic_root_solver_unit.sv
// Throughput: one equation per cycle while the output is not stalled; the 34-stage
// square root and the two division pipelines of 35 + FRACTION_BITS stages each take
// a new word every cycle in which the back pipeline advances.
// Reset (synchronous, active low) empties the pipelines and the queue and sets
// epsilon to one least significant bit; no memory needs clearing.
module quadratic_root_solver_unit #(
    parameter int FRACTION_BITS = 16,
    parameter int QUEUE_DEPTH   = 4
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    qrs_in_if.sink                    i_in,
    qrs_out_if.source                 o_out,
    input  logic                      i_cfg_we,
    input  logic [qrs_pkg::EPS_W-1:0] i_cfg_wdata
);

    logic [qrs_pkg::EPS_W-1:0] r_eps;
    qrs_pkg::t_job             w_front_job;
    logic                      w_front_valid;
    logic                      w_full;
    logic                      w_push;
    qrs_pkg::t_job             w_head;
    logic                      w_empty;
    logic                      w_pop;

    // Epsilon register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= qrs_pkg::EPS_W'(1);
        end else if (i_cfg_we) begin
            r_eps <= i_cfg_wdata;
        end
    end

    assign w_push = w_front_valid && !w_full;

    qrs_front #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_eps       (r_eps),
        .i_in        (i_in),
        .o_job       (w_front_job),
        .o_job_valid (w_front_valid),
        .i_job_ready (!w_full)
    );

    qrs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_front_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_head),
        .o_empty (w_empty)
    );

    qrs_back #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (w_head),
        .i_job_valid (!w_empty),
        .o_job_pop   (w_pop),
        .o_out       (o_out)
    );

    // Two real roots come out in ascending order, also after saturation.
    a_two_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.solution_kind == qrs_pkg::KIND_TWO)
        |-> (o_out.root_low <= o_out.root_high))
        else $error("two real roots out of order");

    // Identities and contradictions carry no roots.
    a_no_roots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.solution_kind == qrs_pkg::KIND_ALL
                      || o_out.solution_kind == qrs_pkg::KIND_NONE))
        |-> (o_out.root_low == '0 && o_out.root_high == '0 && !o_out.overflow))
        else $error("root fields set without roots");

    // A single root leaves the upper field clear.
    a_single_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.solution_kind == qrs_pkg::KIND_LINEAR
                      || o_out.solution_kind == qrs_pkg::KIND_DOUBLE))
        |-> (o_out.root_high == '0))
        else $error("upper root set for a single root");

    // Overflow means some root sits at a saturation bound.
    a_ovf_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.overflow)
        |-> ($unsigned(o_out.root_low) == qrs_pkg::SAT_MAX
          || $unsigned(o_out.root_low) == qrs_pkg::SAT_MIN
          || $unsigned(o_out.root_high) == qrs_pkg::SAT_MAX
          || $unsigned(o_out.root_high) == qrs_pkg::SAT_MIN))
        else $error("overflow without a saturated root");

endmodule
